// File: sv/rrr_pkg.sv
package rrr_pkg;

	localparam int F     = 14;
	localparam int IW    = 16;
	localparam int RW    = 15;
	localparam int CFG_IW = 1;
	localparam int DW    = 2 * IW + 2;
	localparam int CW    = F + 1;
	localparam int AXW   = IW + 1;
	localparam int RP_W  = AXW + DW;
	localparam int RFW   = RP_W - 2 * F + 1;
	localparam int PW    = IW + F + 2;
	localparam int PRW   = PW + RW + 1;
	localparam int PERP_W = PRW - (F + 12);
	localparam int SQW   = 2 * PERP_W;
	localparam int DPW   = SQW + 2;
	localparam int QW    = DPW + 1;
	localparam int SW    = (QW + 1) / 2;
	localparam int TW    = 2 * SW;
	localparam int AXSW  = AXW + SW + 1;
	localparam int DFW   = AXSW - F + 1;
	localparam int RRW   = 2 * RW;
	localparam int S2W   = F + 1;
	localparam int TIRW  = RRW + S2W;
	localparam int ONEW  = 2 * F + 1;

	localparam logic [CFG_IW-1:0] REG_INDEX_RATIO   = 1'd0;
	localparam logic [CFG_IW-1:0] REG_INVERSE_INDEX = 1'd1;
	localparam logic [RW-1:0] INDEX_RATIO_RST   = 15'd6144;
	localparam logic [RW-1:0] INVERSE_INDEX_RST = 15'd2731;

	typedef struct packed {
		logic signed [IW-1:0] incident_x;
		logic signed [IW-1:0] incident_y;
		logic signed [IW-1:0] incident_z;
		logic signed [IW-1:0] normal_x;
		logic signed [IW-1:0] normal_y;
		logic signed [IW-1:0] normal_z;
	} hit_t;

	typedef struct packed {
		logic signed [IW-1:0] reflect_x;
		logic signed [IW-1:0] reflect_y;
		logic signed [IW-1:0] reflect_z;
		logic signed [IW-1:0] refract_x;
		logic signed [IW-1:0] refract_y;
		logic signed [IW-1:0] refract_z;
		logic                 total_internal;
		logic                 front_face;
	} res_t;

	typedef struct packed {
		logic [2:0][PERP_W-1:0] perp;
		logic [2:0][AXW-1:0]    ax;
		logic [2:0][RFW-1:0]    refl;
		logic                   tir;
		logic                   front;
	} geo_t;

	function automatic logic signed [IW-1:0] sat16(input logic signed [31:0] v);
		logic signed [IW-1:0] r;
		if (v > 32'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -32'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[IW-1:0];
		end
		return r;
	endfunction

endpackage

// File: sv/rrr_if.sv
interface rrr_hit_if;
	logic             valid;
	logic             ready;
	rrr_pkg::hit_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rrr_res_if;
	logic             valid;
	logic             ready;
	rrr_pkg::res_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/ray_reflect_refract.sv
// Stages from an accepted item to its result: 8 geometry stages, 24 square root
// stages of one root bit each, 2 output stages.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: arst_n clears all valid bits and loads index_ratio = 6144 and
// inverse_index = 2731; no item is lost or repeated across a stall.
module ray_reflect_refract (
	input  logic                          clk,
	input  logic                          arst_n,
	rrr_hit_if.sink                       hit,
	rrr_res_if.source                     result,
	input  logic                          cfg_we,
	input  logic [rrr_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [rrr_pkg::RW-1:0]        cfg_data
);
	logic en;
	logic [rrr_pkg::RW-1:0] index_ratio_q, inverse_index_q;
	logic geo_v, sq_v, res_v;
	rrr_pkg::geo_t geo, geo_sq;
	logic [rrr_pkg::QW-1:0] q;
	logic [rrr_pkg::SW-1:0] root;

	assign en = !res_v || result.ready;
	assign hit.ready = en;
	assign result.valid = res_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_ratio_q <= rrr_pkg::INDEX_RATIO_RST;
			inverse_index_q <= rrr_pkg::INVERSE_INDEX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rrr_pkg::REG_INDEX_RATIO: index_ratio_q <= cfg_data;
				rrr_pkg::REG_INVERSE_INDEX: inverse_index_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rrr_geom u_geom (
		.clk, .arst_n, .en,
		.v_in(hit.valid), .item(hit.data),
		.index_ratio(index_ratio_q), .inverse_index(inverse_index_q),
		.v_out(geo_v), .geo(geo), .q(q)
	);

	rrr_sqrt u_sqrt (
		.clk, .arst_n, .en,
		.v_in(geo_v), .geo_in(geo), .q(q),
		.v_out(sq_v), .geo_out(geo_sq), .root(root)
	);

	rrr_refract u_refract (
		.clk, .arst_n, .en,
		.v_in(sq_v), .geo(geo_sq), .root(root),
		.v_out(res_v), .res(result.data)
	);
endmodule

// File: sv/rrr_geom.sv
module rrr_geom (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           v_in,
	input  rrr_pkg::hit_t                  item,
	input  logic [rrr_pkg::RW-1:0]         index_ratio,
	input  logic [rrr_pkg::RW-1:0]         inverse_index,
	output logic                           v_out,
	output rrr_pkg::geo_t                  geo,
	output logic [rrr_pkg::QW-1:0]         q
);
	localparam int F = rrr_pkg::F;
	localparam logic signed [rrr_pkg::DW-1:0] D_HALF = rrr_pkg::DW'(1) <<< (F - 1);
	localparam logic signed [rrr_pkg::RP_W-1:0] RP_HALF = rrr_pkg::RP_W'(1) <<< (2 * F - 1);
	localparam logic signed [rrr_pkg::PRW-1:0] PR_HALF = rrr_pkg::PRW'(1) <<< (F + 11);
	localparam logic [rrr_pkg::CW-1:0] ONE = rrr_pkg::CW'(1) << F;
	localparam logic [rrr_pkg::ONEW-1:0] ONE2 = rrr_pkg::ONEW'(1) << (2 * F);
	localparam logic [rrr_pkg::TIRW-1:0] TIR_LIM = rrr_pkg::TIRW'(1) << (24 + F);

	logic [8:1] v_s;

	logic signed [rrr_pkg::IW-1:0] inc_s1 [3], nrm_s1 [3];
	logic signed [2*rrr_pkg::IW-1:0] prod_s1 [3];

	logic signed [rrr_pkg::IW-1:0] inc_s2 [3], nrm_s2 [3];
	logic signed [rrr_pkg::DW-1:0] d_s2;

	logic signed [rrr_pkg::IW-1:0] inc_s3 [3];
	logic signed [rrr_pkg::RP_W-1:0] rp_s3 [3];
	logic signed [rrr_pkg::AXW-1:0] ax_s3 [3];
	logic [rrr_pkg::CW-1:0] c_s3;
	logic [rrr_pkg::RW-1:0] r_s3;
	logic front_s3;

	logic signed [rrr_pkg::RFW-1:0] refl_s4 [3];
	logic signed [rrr_pkg::PW-1:0] p_s4 [3];
	logic signed [rrr_pkg::AXW-1:0] ax_s4 [3];
	logic [rrr_pkg::RRW-1:0] cc_s4, rr_s4;
	logic [rrr_pkg::RW-1:0] r_s4;
	logic front_s4;

	logic signed [rrr_pkg::RFW-1:0] refl_s5 [3];
	logic signed [rrr_pkg::PRW-1:0] pr_s5 [3];
	logic signed [rrr_pkg::AXW-1:0] ax_s5 [3];
	logic [rrr_pkg::RRW-1:0] rr_s5;
	logic [rrr_pkg::S2W-1:0] s2_s5;
	logic front_s5;

	logic signed [rrr_pkg::RFW-1:0] refl_s6 [3];
	logic signed [rrr_pkg::PERP_W-1:0] perp_s6 [3];
	logic signed [rrr_pkg::AXW-1:0] ax_s6 [3];
	logic tir_s6, front_s6;

	logic signed [rrr_pkg::RFW-1:0] refl_s7 [3];
	logic signed [rrr_pkg::PERP_W-1:0] perp_s7 [3];
	logic signed [rrr_pkg::SQW-1:0] sq_s7 [3];
	logic signed [rrr_pkg::AXW-1:0] ax_s7 [3];
	logic tir_s7, front_s7;

	logic [rrr_pkg::QW-1:0] q_s8;
	rrr_pkg::geo_t geo_s8;

	logic signed [rrr_pkg::DW-1:0] absd, cr;
	logic signed [rrr_pkg::DPW-1:0] dp;
	logic signed [rrr_pkg::QW-1:0] qd;

	always_comb begin
		absd = d_s2[rrr_pkg::DW-1] ? -d_s2 : d_s2;
		cr = (absd + D_HALF) >>> F;
		dp = rrr_pkg::DPW'(sq_s7[0]) + rrr_pkg::DPW'(sq_s7[1]) + rrr_pkg::DPW'(sq_s7[2]);
		qd = rrr_pkg::QW'($signed({1'b0, ONE2})) - rrr_pkg::QW'(dp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[7:1], v_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inc_s1[0] <= item.incident_x;
			inc_s1[1] <= item.incident_y;
			inc_s1[2] <= item.incident_z;
			nrm_s1[0] <= item.normal_x;
			nrm_s1[1] <= item.normal_y;
			nrm_s1[2] <= item.normal_z;
			prod_s1[0] <= item.incident_x * item.normal_x;
			prod_s1[1] <= item.incident_y * item.normal_y;
			prod_s1[2] <= item.incident_z * item.normal_z;

			inc_s2 <= inc_s1;
			nrm_s2 <= nrm_s1;
			d_s2 <= rrr_pkg::DW'(prod_s1[0]) + rrr_pkg::DW'(prod_s1[1])
				+ rrr_pkg::DW'(prod_s1[2]);

			inc_s3 <= inc_s2;
			c_s3 <= (cr > rrr_pkg::DW'(ONE)) ? ONE : cr[rrr_pkg::CW-1:0];
			front_s3 <= d_s2[rrr_pkg::DW-1];
			r_s3 <= d_s2[rrr_pkg::DW-1] ? inverse_index : index_ratio;

			cc_s4 <= rrr_pkg::RRW'(c_s3) * rrr_pkg::RRW'(c_s3);
			rr_s4 <= rrr_pkg::RRW'(r_s3) * rrr_pkg::RRW'(r_s3);
			r_s4 <= r_s3;
			front_s4 <= front_s3;
			ax_s4 <= ax_s3;

			s2_s5 <= rrr_pkg::S2W'((ONE2 - rrr_pkg::ONEW'(cc_s4)) >> F);
			rr_s5 <= rr_s4;
			refl_s5 <= refl_s4;
			ax_s5 <= ax_s4;
			front_s5 <= front_s4;

			tir_s6 <= (rrr_pkg::TIRW'(rr_s5) * rrr_pkg::TIRW'(s2_s5)) > TIR_LIM;
			refl_s6 <= refl_s5;
			ax_s6 <= ax_s5;
			front_s6 <= front_s5;

			refl_s7 <= refl_s6;
			perp_s7 <= perp_s6;
			ax_s7 <= ax_s6;
			tir_s7 <= tir_s6;
			front_s7 <= front_s6;

			q_s8 <= qd[rrr_pkg::QW-1] ? rrr_pkg::QW'(-qd) : rrr_pkg::QW'(qd);
			geo_s8.tir <= tir_s7;
			geo_s8.front <= front_s7;

			for (int i = 0; i < 3; i++) begin
				rp_s3[i] <= (rrr_pkg::RP_W'(nrm_s2[i]) <<< 1) * rrr_pkg::RP_W'(d_s2);
				ax_s3[i] <= d_s2[rrr_pkg::DW-1] ? rrr_pkg::AXW'(nrm_s2[i])
					: -rrr_pkg::AXW'(nrm_s2[i]);
				refl_s4[i] <= rrr_pkg::RFW'(inc_s3[i])
					- rrr_pkg::RFW'((rp_s3[i] + RP_HALF) >>> (2 * F));
				p_s4[i] <= (rrr_pkg::PW'(inc_s3[i]) <<< F)
					+ rrr_pkg::PW'(ax_s3[i]) * rrr_pkg::PW'($signed({1'b0, c_s3}));
				pr_s5[i] <= rrr_pkg::PRW'(p_s4[i]) * rrr_pkg::PRW'($signed({1'b0, r_s4}));
				perp_s6[i] <= rrr_pkg::PERP_W'((pr_s5[i] + PR_HALF) >>> (F + 12));
				sq_s7[i] <= rrr_pkg::SQW'(perp_s6[i]) * rrr_pkg::SQW'(perp_s6[i]);
				geo_s8.perp[i] <= perp_s7[i];
				geo_s8.ax[i] <= ax_s7[i];
				geo_s8.refl[i] <= refl_s7[i];
			end
		end
	end

	assign v_out = v_s[8];
	assign geo = geo_s8;
	assign q = q_s8;
endmodule

// File: sv/rrr_sqrt.sv
module rrr_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       v_in,
	input  rrr_pkg::geo_t              geo_in,
	input  logic [rrr_pkg::QW-1:0]     q,
	output logic                       v_out,
	output rrr_pkg::geo_t              geo_out,
	output logic [rrr_pkg::SW-1:0]     root
);
	localparam int SW = rrr_pkg::SW;
	localparam int TW = rrr_pkg::TW;

	logic [SW:1] v_sn;
	logic [TW-1:0] rem_sn [SW];
	logic [SW-1:0] root_sn [SW+1];
	rrr_pkg::geo_t geo_sn [SW+1];

	assign rem_sn[0] = TW'(q);
	assign root_sn[0] = '0;
	assign geo_sn[0] = geo_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn <= '0;
		end else if (en) begin
			v_sn <= {v_sn[SW-1:1], v_in};
		end
	end

	for (genvar k = 0; k < SW; k++) begin : g_step
		localparam int B = SW - 1 - k;
		logic [TW-1:0] trial;
		logic take;
		assign trial = (TW'(root_sn[k]) << (B + 1)) | (TW'(1) << (2 * B));
		assign take = rem_sn[k] >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				geo_sn[k+1] <= geo_sn[k];
				root_sn[k+1] <= take ? (root_sn[k] | (SW'(1) << B)) : root_sn[k];
			end
		end
		if (k < SW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_sn[k+1] <= take ? rem_sn[k] - trial : rem_sn[k];
				end
			end
		end
	end

	assign v_out = v_sn[SW];
	assign geo_out = geo_sn[SW];
	assign root = root_sn[SW];
endmodule

// File: sv/rrr_refract.sv
module rrr_refract (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       v_in,
	input  rrr_pkg::geo_t              geo,
	input  logic [rrr_pkg::SW-1:0]     root,
	output logic                       v_out,
	output rrr_pkg::res_t              res
);
	localparam int F = rrr_pkg::F;
	localparam logic signed [rrr_pkg::AXSW-1:0] AXS_HALF = rrr_pkg::AXSW'(1) <<< (F - 1);

	logic [2:1] v_s;
	logic signed [rrr_pkg::AXSW-1:0] axs_s1 [3];
	rrr_pkg::geo_t geo_s1;
	rrr_pkg::res_t res_s2;
	logic signed [rrr_pkg::DFW-1:0] diff [3];
	logic signed [rrr_pkg::IW-1:0] rf [3], rr [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = rrr_pkg::DFW'($signed(geo_s1.perp[i]))
				- rrr_pkg::DFW'((axs_s1[i] + AXS_HALF) >>> F);
			rf[i] = rrr_pkg::sat16(32'($signed(geo_s1.refl[i])));
			rr[i] = geo_s1.tir ? rf[i] : rrr_pkg::sat16(32'(diff[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[1], v_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1 <= geo;
			for (int i = 0; i < 3; i++) begin
				axs_s1[i] <= rrr_pkg::AXSW'($signed(geo.ax[i]))
					* rrr_pkg::AXSW'($signed({1'b0, root}));
			end
			res_s2.reflect_x <= rf[0];
			res_s2.reflect_y <= rf[1];
			res_s2.reflect_z <= rf[2];
			res_s2.refract_x <= rr[0];
			res_s2.refract_y <= rr[1];
			res_s2.refract_z <= rr[2];
			res_s2.total_internal <= geo_s1.tir;
			res_s2.front_face <= geo_s1.front;
		end
	end

	assign v_out = v_s[2];
	assign res = res_s2;
endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import rrr_pkg::*;

	typedef struct {
		hit_t h;
		bit   known;
		res_t want;
	} hit_row_t;

	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT  = 5000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [RW-1:0] cfg_data;

	rrr_hit_if hit ();
	rrr_res_if result ();

	ray_reflect_refract u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.hit(hit.sink),
		.result(result.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [RW-1:0] back_ratio;
	logic [RW-1:0] front_ratio;
	res_t bounce_q[$];
	int errors;
	int idle_cycles;
	int ready_hold;
	bit sending;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint rnd_shr(longint x, int k);
		return (x + (longint'(1) <<< (k - 1))) >>> k;
	endfunction

	function automatic logic signed [IW-1:0] clip16(longint v);
		if (v > 32767) begin
			return 16'sh7fff;
		end else if (v < -32768) begin
			return 16'sh8000;
		end
		return v[IW-1:0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) begin
			bitv = bitv >> 2;
		end
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic res_t bounce_of(hit_t h);
		longint inc[3];
		longint nrm[3];
		longint ax[3];
		longint perp[3];
		longint refl[3];
		longint d;
		longint c;
		longint dp;
		longint q;
		longint r;
		longint s2;
		longint s;
		bit front;
		bit tir;
		res_t o;
		inc[0] = h.incident_x;
		inc[1] = h.incident_y;
		inc[2] = h.incident_z;
		nrm[0] = h.normal_x;
		nrm[1] = h.normal_y;
		nrm[2] = h.normal_z;
		d = 0;
		dp = 0;
		for (int i = 0; i < 3; i++) begin
			d += inc[i] * nrm[i];
		end
		for (int i = 0; i < 3; i++) begin
			refl[i] = inc[i] - rnd_shr(2 * nrm[i] * d, 2 * F);
		end
		front = d < 0;
		r = front ? longint'(front_ratio) : longint'(back_ratio);
		c = rnd_shr(d < 0 ? -d : d, F);
		if (c > (longint'(1) << F)) begin
			c = longint'(1) << F;
		end
		s2 = ((longint'(1) << (2 * F)) - c * c) >>> F;
		tir = r * r * s2 > (longint'(1) << (24 + F));
		for (int i = 0; i < 3; i++) begin
			ax[i] = front ? nrm[i] : -nrm[i];
		end
		o.reflect_x = clip16(refl[0]);
		o.reflect_y = clip16(refl[1]);
		o.reflect_z = clip16(refl[2]);
		if (tir) begin
			o.refract_x = o.reflect_x;
			o.refract_y = o.reflect_y;
			o.refract_z = o.reflect_z;
		end else begin
			for (int i = 0; i < 3; i++) begin
				perp[i] = rnd_shr(((inc[i] <<< F) + ax[i] * c) * r, F + 12);
				dp += perp[i] * perp[i];
			end
			q = (longint'(1) << (2 * F)) - dp;
			if (q < 0) begin
				q = -q;
			end
			s = longint'(int_sqrt(longint'(q)));
			o.refract_x = clip16(perp[0] - rnd_shr(ax[0] * s, F));
			o.refract_y = clip16(perp[1] - rnd_shr(ax[1] * s, F));
			o.refract_z = clip16(perp[2] - rnd_shr(ax[2] * s, F));
		end
		o.total_internal = tir;
		o.front_face = front;
		return o;
	endfunction

	function automatic hit_t mk_hit(int ix, int iy, int iz, int nx, int ny, int nz);
		hit_t h;
		h.incident_x = 16'(ix);
		h.incident_y = 16'(iy);
		h.incident_z = 16'(iz);
		h.normal_x = 16'(nx);
		h.normal_y = 16'(ny);
		h.normal_z = 16'(nz);
		return h;
	endfunction

	function automatic res_t mk_res(int rx, int ry, int rz, int tx, int ty, int tz,
			bit tir, bit front);
		res_t o;
		o.reflect_x = 16'(rx);
		o.reflect_y = 16'(ry);
		o.reflect_z = 16'(rz);
		o.refract_x = 16'(tx);
		o.refract_y = 16'(ty);
		o.refract_z = 16'(tz);
		o.total_internal = tir;
		o.front_face = front;
		return o;
	endfunction

	function automatic void unit_vec(output int v[3]);
		real a[3];
		real len;
		do begin
			len = 0.0;
			for (int i = 0; i < 3; i++) begin
				a[i] = real'($urandom_range(0, 4000)) - 2000.0;
				len += a[i] * a[i];
			end
		end while (len < 1.0);
		len = $sqrt(len);
		for (int i = 0; i < 3; i++) begin
			v[i] = $rtoi(a[i] / len * 16384.0 + (a[i] >= 0.0 ? 0.5 : -0.5));
		end
	endfunction

	function automatic int edge_val();
		int pick[6] = '{-32768, 32767, -16384, 16384, 0, -1};
		return pick[$urandom_range(0, 5)];
	endfunction

	function automatic hit_t random_hit();
		int a[3];
		int b[3];
		int k;
		k = $urandom_range(0, 99);
		if (k < 72) begin
			unit_vec(a);
			unit_vec(b);
			if ($urandom_range(0, 3) == 0) begin
				b[$urandom_range(0, 2)] = 0;
			end
		end else if (k < 88) begin
			for (int i = 0; i < 3; i++) begin
				a[i] = int'($signed(16'($urandom)));
				b[i] = int'($signed(16'($urandom)));
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				a[i] = edge_val();
				b[i] = edge_val();
			end
		end
		return mk_hit(a[0], a[1], a[2], b[0], b[1], b[2]);
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) begin
			return 0;
		end else if (k < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 60);
	endfunction

	task automatic send_hit(hit_t h, bit known, res_t want, int gap);
		hit.data <= h;
		hit.valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!hit.ready);
		bounce_q.push_back(known ? want : bounce_of(h));
		if (gap > 0) begin
			hit.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		hit.valid <= 1'b0;
		while (bounce_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [RW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_INDEX_RATIO) begin
			back_ratio = val;
		end else begin
			front_ratio = val;
		end
		@(posedge clk);
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			errors++;
			$display("%0t %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
			if ($urandom_range(0, 99) < 25) begin
				ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
					: $urandom_range(1, 3);
			end
		end
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (result.valid && result.ready) begin
			got = result.data;
			if (bounce_q.size() == 0) begin
				errors++;
				$display("%0t unexpected item expected none actual %h", $time, got);
			end else begin
				want = bounce_q.pop_front();
				check_field("reflect_x", want.reflect_x, got.reflect_x);
				check_field("reflect_y", want.reflect_y, got.reflect_y);
				check_field("reflect_z", want.reflect_z, got.reflect_z);
				check_field("refract_x", want.refract_x, got.refract_x);
				check_field("refract_y", want.refract_y, got.refract_y);
				check_field("refract_z", want.refract_z, got.refract_z);
				check_field("total_internal", want.total_internal, got.total_internal);
				check_field("front_face", want.front_face, got.front_face);
			end
		end
	end

	always @(posedge clk) begin
		if ((hit.valid && hit.ready) || (result.valid && result.ready) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("ray_reflect_refract: mismatch");
				$finish;
			end
		end
	end

	initial begin
		hit_row_t rows[$];
		logic [RW-1:0] settings[5][2];
		res_t none;
		none = '0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		hit.valid <= 1'b0;
		hit.data <= '0;
		back_ratio = INDEX_RATIO_RST;
		front_ratio = INVERSE_INDEX_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Head-on hit after reset, then the all-zero item, which counts as a back face.
		rows.push_back('{mk_hit(0, 0, -16384, 0, 0, 16384), 1,
			mk_res(0, 0, 16384, 0, 0, -16384, 0, 1)});
		rows.push_back('{mk_hit(0, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 0, 0, 1, 0)});
		rows.push_back('{mk_hit(16384, 0, 0, 0, 16384, 0), 0, none});
		rows.push_back('{mk_hit(0, 0, 16384, 0, 0, 16384), 0, none});
		rows.push_back('{mk_hit(11585, 0, 11585, 0, 0, 16384), 0, none});
		rows.push_back('{mk_hit(11585, 0, -11585, 0, 0, 16384), 0, none});
		rows.push_back('{mk_hit(16000, 0, 3500, 0, 0, 16384), 0, none});
		rows.push_back('{mk_hit(-32768, -32768, -32768, 32767, 32767, 32767), 0, none});
		rows.push_back('{mk_hit(32767, 32767, 32767, 32767, 32767, 32767), 0, none});
		rows.push_back('{mk_hit(-32768, 32767, -32768, -32768, 32767, -32768), 0, none});
		rows.push_back('{mk_hit(16384, -16384, 16384, -16384, 16384, -16384), 0, none});
		rows.push_back('{mk_hit(-1, -1, -1, -1, -1, -1), 0, none});
		rows.push_back('{mk_hit(9459, -9459, -9459, 0, -16384, 0), 0, none});
		rows.push_back('{mk_hit(0, 16384, 0, 0, 0, 0), 0, none});
		foreach (rows[i]) begin
			send_hit(rows[i].h, rows[i].known, rows[i].want, pick_gap());
		end
		wait_idle();

		settings = '{'{15'd1024, 15'd16384}, '{15'd32767, 15'd512},
			'{15'd4096, 15'd4096}, '{15'd6144, 15'd2731}, '{15'd0, 15'd0}};
		settings[4][0] = RW'($urandom_range(1024, 32767));
		settings[4][1] = RW'($urandom_range(512, 16384));
		for (int p = 0; p < 6; p++) begin
			if (p > 0) begin
				write_reg(REG_INDEX_RATIO, settings[p - 1][0]);
				write_reg(REG_INVERSE_INDEX, settings[p - 1][1]);
			end
			for (int n = 0; n < 190; n++) begin
				if (n == 95) begin
					wait_idle();
				end
				send_hit(random_hit(), 0, none, (n < 40) ? 0 : pick_gap());
			end
			wait_idle();
		end

		if (errors == 0) begin
			$display("ray_reflect_refract: match");
		end else begin
			$display("ray_reflect_refract: mismatch");
		end
		$finish;
	end

endmodule
